>>> hdl/cnu_pkg.sv
// Shared constants and types of the combinatorial number unit.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cnu_pkg;

	localparam int ROW_DEPTH = 128;
	localparam int ADDR_W    = $clog2(ROW_DEPTH);
	localparam int DATA_W    = 32;

	localparam logic [1:0] OP_BINOM = 2'd0;
	localparam logic [1:0] OP_FACT  = 2'd1;
	localparam logic [1:0] OP_STIR  = 2'd2;

	typedef enum logic [2:0] {
		WORK_HOLD,
		WORK_ZERO,
		WORK_ONE,
		WORK_MUL,
		WORK_RAM
	} work_op_t;

	typedef struct packed {
		logic              clr_wr;
		logic              rd_en;
		logic              row_rd;
		logic              rd_first;
		logic              rd_zero;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        factor;
		logic              row0_set;
		logic              row0_clr;
		work_op_t          work_op;
		logic              out_load;
	} cmd_t;

endpackage

`default_nettype wire

>>> hdl/cnu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cnu_ram #(
	parameter  int WIDTH = 32,
	parameter  int DEPTH = 128,
	localparam int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/cnu_datapath.sv
// Datapath: row store, row update multiply-add, factorial product and result registers.
// Depends on cnu_pkg and cnu_ram.
`timescale 1ns / 1ps
`default_nettype none

module cnu_datapath (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cnu_pkg::cmd_t         cmd,
	output logic [cnu_pkg::DATA_W-1:0] result
);
	import cnu_pkg::*;

	logic              row_s1;
	logic              first_s1;
	logic              zero_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [7:0]        factor_s1;

	logic [DATA_W-1:0] prev_q;
	logic [DATA_W-1:0] row0_q;
	logic [DATA_W-1:0] work_q;
	logic [DATA_W-1:0] out_q;

	logic [DATA_W-1:0] rd_data;
	logic [DATA_W-1:0] lower;
	logic [DATA_W+7:0] row_prod;
	logic [DATA_W+7:0] fact_prod;
	logic [DATA_W-1:0] cell_new;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [DATA_W-1:0] wr_data;

	// new[j] = old[j-1] + factor * old[j], walking j downwards
	assign lower     = zero_s1 ? row0_q : rd_data;
	assign row_prod  = {8'd0, prev_q} * {{DATA_W{1'b0}}, factor_s1};
	assign fact_prod = {8'd0, work_q} * {{DATA_W{1'b0}}, cmd.factor};
	assign cell_new  = lower + row_prod[DATA_W-1:0];

	assign wr_en   = cmd.clr_wr || (row_s1 && !first_s1);
	assign wr_addr = cmd.clr_wr ? cmd.addr : addr_s1 + ADDR_W'(1);
	assign wr_data = cmd.clr_wr ? '0 : cell_new;

	cnu_ram #(
		.WIDTH(DATA_W),
		.DEPTH(ROW_DEPTH)
	) u_row_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (cmd.rd_en),
		.rd_addr(cmd.addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_s1 <= 1'b0;
		end else begin
			row_s1 <= cmd.row_rd;
		end
	end

	always_ff @(posedge clk) begin
		first_s1  <= cmd.rd_first;
		zero_s1   <= cmd.rd_zero;
		addr_s1   <= cmd.addr;
		factor_s1 <= cmd.factor;
		if (row_s1) begin
			prev_q <= lower;
		end
		if (cmd.row0_set) begin
			row0_q <= DATA_W'(1);
		end else if (cmd.row0_clr) begin
			row0_q <= '0;
		end
		case (cmd.work_op)
			WORK_ZERO: work_q <= '0;
			WORK_ONE:  work_q <= DATA_W'(1);
			WORK_MUL:  work_q <= fact_prod[DATA_W-1:0];
			WORK_RAM:  work_q <= rd_data;
			default:   work_q <= work_q;
		endcase
		if (cmd.out_load) begin
			out_q <= work_q;
		end
	end

	assign result = out_q;

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && cmd.rd_en) |-> (wr_addr != cmd.addr))
		else $error("row store read and write at one address");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clr_wr && row_s1 && !first_s1))
		else $error("clear and row update write together");

	a_zero_not_first: assert property (@(posedge clk) disable iff (!arst_n)
		(row_s1 && zero_s1) |-> !first_s1)
		else $error("row began at cell zero");

endmodule

`default_nettype wire

>>> hdl/cnu_ctrl.sv
// Controller: operand decode, row sequencing, factorial steps and output handshake.
// Depends on cnu_pkg; drives the datapath through cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module cnu_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [15:0]   s_tdata,
	input  wire logic [1:0]    s_tuser,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output cnu_pkg::cmd_t      cmd
);
	import cnu_pkg::*;

	typedef enum logic [2:0] {
		IDLE,
		INIT,
		ROW,
		ROW_END,
		READ,
		CAPTURE,
		FACT,
		DONE
	} state_t;

	typedef enum logic [1:0] {
		DEC_ZERO,
		DEC_ONE,
		DEC_FACT,
		DEC_FILL
	} dec_t;

	state_t      state_q;
	logic [6:0]  n_q;
	logic [6:0]  k_q;
	logic        stir_q;
	logic [6:0]  i_q;
	logic [6:0]  j_q;
	logic        first_q;
	logic        m_tvalid_q;

	logic signed [7:0] n_s;
	logic signed [7:0] k_s;
	logic signed [8:0] k9;
	logic signed [8:0] nk;
	logic signed [8:0] kf;
	dec_t              dec_kind;
	logic [6:0]        dec_n;
	logic [6:0]        dec_k;
	logic [6:0]        i_nxt;
	logic [6:0]        top_nxt;

	always_comb begin
		n_s      = s_tdata[7:0];
		k_s      = s_tdata[15:8];
		k9       = {k_s[7], k_s};
		nk       = {n_s[7], n_s} - k9;
		kf       = (k9 > nk) ? nk : k9;
		dec_n    = n_s[6:0];
		dec_k    = k_s[6:0];
		dec_kind = DEC_ZERO;
		unique case (s_tuser)
			OP_BINOM: begin
				dec_k = kf[6:0];
				if (kf[8] || int'(kf) >= ROW_DEPTH) begin
					dec_kind = DEC_ZERO;
				end else if (kf == 9'sd0) begin
					dec_kind = DEC_ONE;
				end else begin
					dec_kind = DEC_FILL;
				end
			end
			OP_FACT: begin
				dec_kind = (n_s < 8'sd2) ? DEC_ONE : DEC_FACT;
			end
			OP_STIR: begin
				if (n_s == k_s) begin
					dec_kind = DEC_ONE;
				end else if (n_s <= 8'sd0 || k_s <= 8'sd0 || k_s > n_s) begin
					dec_kind = DEC_ZERO;
				end else if (int'(k_s) >= ROW_DEPTH) begin
					dec_kind = DEC_ZERO;
				end else begin
					dec_kind = DEC_FILL;
				end
			end
			default: dec_kind = DEC_ZERO;
		endcase
	end

	assign i_nxt   = i_q + 7'd1;
	assign top_nxt = (i_nxt < k_q) ? i_nxt : k_q;

	always_comb begin
		cmd         = '0;
		cmd.work_op = WORK_HOLD;
		cmd.addr    = ADDR_W'(j_q);
		cmd.factor  = stir_q ? {1'b0, i_q - 7'd1} : 8'd1;
		unique case (state_q)
			IDLE: begin
				if (s_tvalid) begin
					cmd.row0_set = 1'b1;
					unique case (dec_kind) inside
						DEC_ZERO:           cmd.work_op = WORK_ZERO;
						DEC_ONE, DEC_FACT:  cmd.work_op = WORK_ONE;
						default:            cmd.work_op = WORK_HOLD;
					endcase
				end
			end
			INIT: cmd.clr_wr = 1'b1;
			ROW: begin
				cmd.rd_en    = 1'b1;
				cmd.row_rd   = 1'b1;
				cmd.rd_first = first_q;
				cmd.rd_zero  = (j_q == 7'd0);
			end
			ROW_END: cmd.row0_clr = stir_q;
			READ: begin
				cmd.rd_en = 1'b1;
				cmd.addr  = ADDR_W'(k_q);
			end
			CAPTURE: cmd.work_op = WORK_RAM;
			FACT: begin
				cmd.work_op = WORK_MUL;
				cmd.factor  = {1'b0, i_q};
			end
			DONE: cmd.out_load = !m_tvalid_q || m_tready;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			n_q        <= '0;
			k_q        <= '0;
			stir_q     <= 1'b0;
			i_q        <= '0;
			j_q        <= '0;
			first_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == DONE && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						n_q    <= dec_n;
						k_q    <= dec_k;
						stir_q <= (s_tuser == OP_STIR);
						unique case (dec_kind) inside
							DEC_ZERO, DEC_ONE: state_q <= DONE;
							DEC_FACT: begin
								i_q     <= 7'd2;
								state_q <= FACT;
							end
							default: begin
								j_q     <= 7'd1;
								state_q <= INIT;
							end
						endcase
					end
				end
				INIT: begin
					if (j_q == k_q) begin
						i_q     <= 7'd1;
						j_q     <= 7'd1;
						first_q <= 1'b1;
						state_q <= ROW;
					end else begin
						j_q <= j_q + 7'd1;
					end
				end
				ROW: begin
					first_q <= 1'b0;
					if (j_q == 7'd0) begin
						state_q <= ROW_END;
					end else begin
						j_q <= j_q - 7'd1;
					end
				end
				ROW_END: begin
					if (i_q == n_q) begin
						state_q <= READ;
					end else begin
						i_q     <= i_nxt;
						j_q     <= top_nxt;
						first_q <= 1'b1;
						state_q <= ROW;
					end
				end
				READ:    state_q <= CAPTURE;
				CAPTURE: state_q <= DONE;
				FACT: begin
					i_q <= i_nxt;
					if (i_q == n_q) begin
						state_q <= DONE;
					end
				end
				DONE: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= IDLE;
					end
				end
			endcase
		end
	end

	assign s_tready = (state_q == IDLE);
	assign m_tvalid = m_tvalid_q;

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ROW) |-> (j_q <= k_q))
		else $error("row cell beyond k");

	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == DONE))
		else $error("result raised outside completion");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q != IDLE))
		else $error("accepted word left no work");

endmodule

`default_nettype wire

>>> hdl/combinatorial_number_unit.sv
// Top level of the combinatorial number unit: binomial, factorial, Stirling first kind.
// Depends on cnu_pkg, cnu_ctrl, cnu_datapath (and cnu_ram below it).
//
// One word in, one 32-bit result out, modulo 2^32. One word is worked on at a time;
// s_tready is high only between words. Factorial forms one product per cycle.
// Binomial and Stirling clear k cells of the row store, then fill rows 1..n at one
// cell per cycle through the single read port and the single write port. A finished
// result sits in the output register while the next word is taken.
`timescale 1ns / 1ps
`default_nettype none

module combinatorial_number_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // n_value[7:0], k_value[15:8]
	input  wire logic [1:0]  s_tuser,   // opcode[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata    // result_value[31:0]
);
	import cnu_pkg::*;

	cmd_t cmd;

	cnu_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd)
	);

	cnu_datapath u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.result(m_tdata)
	);

endmodule

`default_nettype wire
